FILE: sv/dmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

   localparam int MAX_COLS    = 32;
   localparam int MAX_ROWS    = 32;
   localparam int STACK_DEPTH = 1024;

   localparam int POS_W    = 5;
   localparam int DIM_W    = 6;
   localparam int RAND_W   = 16;
   localparam int WALL_W   = 7;
   localparam int CELL_W   = 2 * POS_W;
   localparam int CELLS    = MAX_COLS * MAX_ROWS;
   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int STACK_CW = STACK_AW + 1;
   localparam int VCNT_W   = $clog2(CELLS) + 1;
   localparam int AREA_W   = 2 * DIM_W;
   localparam int EPOCH_W  = 4;

   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [DIM_W-1:0]    dim_type;
   typedef logic [RAND_W-1:0]   rand_type;
   typedef logic [WALL_W-1:0]   wall_type;
   typedef logic [CELL_W-1:0]   cell_type;
   typedef logic [STACK_CW-1:0] stk_cnt_type;
   typedef logic [VCNT_W-1:0]   vis_cnt_type;
   typedef logic [AREA_W-1:0]   area_type;
   typedef logic [EPOCH_W-1:0]  epoch_type;

   localparam dim_type     DIM_MAX_COLS = dim_type'(MAX_COLS);
   localparam dim_type     DIM_MAX_ROWS = dim_type'(MAX_ROWS);
   localparam stk_cnt_type STACK_FULL   = stk_cnt_type'(STACK_DEPTH);
   localparam vis_cnt_type CELL_TOTAL   = vis_cnt_type'(CELLS);

   // Item kinds.
   localparam logic REQ_RESTART = 1'b0;
   localparam logic REQ_STEP    = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // Neighbor directions in probe order.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   typedef struct packed {
      logic     carved;
      wall_type wall_row;
      wall_type wall_col;
      logic     backtracked;
      logic     done_res;
   } res_type;

   // A zero register acts as one, anything above the grid size as the grid size.
   function automatic dim_type eff_dim(input dim_type r, input dim_type maxv);
      dim_type d;
      if (r == '0) begin
         d = dim_type'(1);
      end else if (r > maxv) begin
         d = maxv;
      end else begin
         d = r;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: sv/dfs_maze_carver.sv
`timescale 1ns / 1ps
`default_nettype none

// A step item probes the four neighbors with visited-map reads through one port, then chooses and
// moves, ends or stays put at a dead end, or pops the branch stack. A restart takes the remainder
// by the width; every 15th restart adds a sweep of the visited memory. One item is in flight at
// a time: the next item is taken in the cycle in which rsp_valid rises, later while a held result
// blocks the output register.
// Reset is synchronous; then the visited memory is swept with req_stall high.
module dfs_maze_carver (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire dmc_pkg::rand_type req_rand_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dmc_pkg::pos_type       rsp_pos_x,
   output dmc_pkg::pos_type       rsp_pos_y,
   output logic                   rsp_carved,
   output dmc_pkg::wall_type      rsp_wall_row,
   output dmc_pkg::wall_type      rsp_wall_col,
   output logic                   rsp_backtracked,
   output logic                   rsp_done_res,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire dmc_pkg::dim_type  csr_data
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_RSTART = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_PROBE  = 4'd4;
   localparam logic [3:0] S_CHOOSE = 4'd5;
   localparam logic [3:0] S_MOVE   = 4'd6;
   localparam logic [3:0] S_POP1   = 4'd7;
   localparam logic [3:0] S_POP2   = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0]           state_ff, state_in;
   dmc_pkg::dim_type     width_ff, width_in;
   dmc_pkg::dim_type     height_ff, height_in;
   dmc_pkg::epoch_type   epoch_ff, epoch_in;
   dmc_pkg::cell_type    clr_ff, clr_in;
   logic                 pend_ff, pend_in;
   dmc_pkg::pos_type     cur_x_ff, cur_x_in;
   dmc_pkg::pos_type     cur_y_ff, cur_y_in;
   dmc_pkg::stk_cnt_type stk_cnt_ff, stk_cnt_in;
   dmc_pkg::vis_cnt_type vis_cnt_ff, vis_cnt_in;
   logic [2:0]           dir_ff, dir_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   dmc_pkg::rand_type    rand_ff, rand_in;
   logic [3:0]           free_ff, free_in;
   logic [1:0]           k_ff, k_in;
   dmc_pkg::res_type     res_ff, res_in;
   dmc_pkg::res_type     rsp_res_ff, rsp_res_in;
   dmc_pkg::pos_type     rsp_x_ff, rsp_x_in;
   dmc_pkg::pos_type     rsp_y_ff, rsp_y_in;

   logic                 vis_we;
   dmc_pkg::cell_type    vis_waddr;
   dmc_pkg::epoch_type   vis_wdata;
   dmc_pkg::cell_type    vis_raddr;
   dmc_pkg::epoch_type   vis_rdata;
   logic                 stk_we;
   logic [dmc_pkg::STACK_AW-1:0] stk_waddr;
   logic [dmc_pkg::STACK_AW-1:0] stk_raddr;
   dmc_pkg::cell_type    stk_rdata;
   logic                 rem_start;
   dmc_pkg::dim_type     rem_dvsr;
   logic                 rem_done;
   dmc_pkg::dim_type     rem_value;

   dmc_pkg::dim_type     w_eff;
   dmc_pkg::dim_type     h_eff;
   dmc_pkg::area_type    area;
   dmc_pkg::cell_type    cur_cell;
   logic [3:0]           inb;
   logic [2:0]           n_open;
   logic [1:0]           prev_dir;
   logic [1:0]           move_dir;
   dmc_pkg::cell_type    move_cell;
   dmc_pkg::stk_cnt_type stk_cnt_m1;
   dmc_pkg::stk_cnt_type stk_cnt_m2;
   logic                 xfer;

   function automatic dmc_pkg::cell_type nbr(input logic [1:0] dir,
                                             input dmc_pkg::pos_type x,
                                             input dmc_pkg::pos_type y);
      dmc_pkg::pos_type nx;
      dmc_pkg::pos_type ny;
      nx = x;
      ny = y;
      unique case (dir)
         dmc_pkg::DIR_UP:    ny = y - dmc_pkg::pos_type'(1);
         dmc_pkg::DIR_RIGHT: nx = x + dmc_pkg::pos_type'(1);
         dmc_pkg::DIR_DOWN:  ny = y + dmc_pkg::pos_type'(1);
         dmc_pkg::DIR_LEFT:  nx = x - dmc_pkg::pos_type'(1);
      endcase
      return {ny, nx};
   endfunction

   // Direction of the k-th open neighbor, counted in probe order.
   function automatic logic [1:0] kth_open(input logic [3:0] f, input logic [1:0] k);
      logic [1:0] seen;
      logic [1:0] d;
      logic       hit;
      seen = '0;
      d    = '0;
      hit  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (f[i] && !hit) begin
            if (seen == k) begin
               d   = 2'(i);
               hit = 1'b1;
            end
            seen = seen + 2'd1;
         end
      end
      return d;
   endfunction

   // Since 4 is 1 modulo 3, the base-4 digits are summed and the sum is folded again.
   function automatic logic [1:0] rem_by_3(input dmc_pkg::rand_type v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      logic [1:0] r;
      s = '0;
      for (int i = 0; i < dmc_pkg::RAND_W / 2; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         r = 2'(u - 3'd3);
      end else begin
         r = u[1:0];
      end
      return r;
   endfunction

   assign w_eff    = dmc_pkg::eff_dim(width_ff, dmc_pkg::DIM_MAX_COLS);
   assign h_eff    = dmc_pkg::eff_dim(height_ff, dmc_pkg::DIM_MAX_ROWS);
   assign area     = dmc_pkg::area_type'(w_eff) * dmc_pkg::area_type'(h_eff);
   assign cur_cell = {cur_y_ff, cur_x_ff};

   assign inb[dmc_pkg::DIR_UP]    = (cur_y_ff != '0);
   assign inb[dmc_pkg::DIR_RIGHT] = ({1'b0, cur_x_ff} + dmc_pkg::dim_type'(1)) < w_eff;
   assign inb[dmc_pkg::DIR_DOWN]  = ({1'b0, cur_y_ff} + dmc_pkg::dim_type'(1)) < h_eff;
   assign inb[dmc_pkg::DIR_LEFT]  = (cur_x_ff != '0);

   assign n_open = 3'(free_ff[0]) + 3'(free_ff[1]) + 3'(free_ff[2]) + 3'(free_ff[3]);
   assign prev_dir   = dir_ff[1:0] - 2'd1;
   assign move_dir   = kth_open(free_ff, k_ff);
   assign move_cell  = nbr(move_dir, cur_x_ff, cur_y_ff);
   assign stk_cnt_m1 = stk_cnt_ff - dmc_pkg::stk_cnt_type'(1);
   assign stk_cnt_m2 = stk_cnt_ff - dmc_pkg::stk_cnt_type'(2);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dmc_pkg::CSR_WIDTH:  width_in  = csr_data;
            dmc_pkg::CSR_HEIGHT: height_in = csr_data;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      epoch_in   = epoch_ff;
      clr_in     = clr_ff;
      pend_in    = pend_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      stk_cnt_in = stk_cnt_ff;
      vis_cnt_in = vis_cnt_ff;
      dir_in     = dir_ff;
      rand_in    = rand_ff;
      free_in    = free_ff;
      k_in       = k_ff;
      res_in     = res_ff;
      vis_we     = 1'b0;
      vis_waddr  = cur_cell;
      vis_wdata  = epoch_ff;
      vis_raddr  = nbr(dir_ff[1:0], cur_x_ff, cur_y_ff);
      stk_we     = 1'b0;
      stk_waddr  = stk_cnt_ff[dmc_pkg::STACK_AW-1:0];
      stk_raddr  = stk_cnt_m1[dmc_pkg::STACK_AW-1:0];
      rem_start  = 1'b0;
      rem_dvsr   = w_eff;
      xfer       = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            // Tag 0 never matches a live epoch, so writing it clears a cell.
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = '0;
            clr_in    = clr_ff + dmc_pkg::cell_type'(1);
            if (clr_ff == '1) begin
               epoch_in = dmc_pkg::epoch_type'(1);
               pend_in  = 1'b0;
               state_in = pend_ff ? S_RSTART : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               rand_in = req_rand_value;
               if (req_type == dmc_pkg::REQ_RESTART) begin
                  if (epoch_ff == '1) begin
                     pend_in  = 1'b1;
                     clr_in   = '0;
                     state_in = S_INIT;
                  end else begin
                     epoch_in = epoch_ff + dmc_pkg::epoch_type'(1);
                     state_in = S_RSTART;
                  end
               end else begin
                  dir_in   = '0;
                  state_in = S_PROBE;
               end
            end
         end
         S_RSTART: begin
            rem_start = 1'b1;
            rem_dvsr  = w_eff;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (rem_done) begin
               cur_x_in           = rem_value[dmc_pkg::POS_W-1:0];
               cur_y_in           = '0;
               vis_we             = 1'b1;
               vis_waddr          = {dmc_pkg::pos_type'(0), rem_value[dmc_pkg::POS_W-1:0]};
               vis_cnt_in         = dmc_pkg::vis_cnt_type'(1);
               stk_cnt_in         = '0;
               res_in.carved      = 1'b1;
               res_in.wall_row    = '0;
               res_in.wall_col    = {1'b0, rem_value[dmc_pkg::POS_W-1:0], 1'b1};
               res_in.backtracked = 1'b0;
               res_in.done_res    = 1'b0;
               state_in           = S_OUT;
            end
         end
         S_PROBE: begin
            // Read data is registered in the RAM and returns in the cycle after its address, so capture lags.
            if (dir_ff != '0) begin
               free_in[prev_dir] = inb[prev_dir] && (vis_rdata != epoch_ff);
            end
            dir_in = dir_ff + 3'd1;
            if (dir_ff == 3'd4) begin
               state_in = S_CHOOSE;
            end
         end
         S_CHOOSE: begin
            if (n_open > 3'd1 && stk_cnt_ff < dmc_pkg::STACK_FULL) begin
               stk_we     = 1'b1;
               stk_cnt_in = stk_cnt_ff + dmc_pkg::stk_cnt_type'(1);
            end
            case (n_open)
               3'd0: begin
                  if (stk_cnt_ff <= dmc_pkg::stk_cnt_type'(1)) begin
                     res_in.carved      = 1'b0;
                     res_in.wall_row    = '0;
                     res_in.wall_col    = '0;
                     res_in.backtracked = 1'b0;
                     res_in.done_res    = dmc_pkg::area_type'(vis_cnt_ff) >= area;
                     state_in           = S_OUT;
                  end else begin
                     state_in = S_POP1;
                  end
               end
               3'd1: begin
                  k_in     = 2'd0;
                  state_in = S_MOVE;
               end
               3'd2: begin
                  k_in     = {1'b0, rand_ff[0]};
                  state_in = S_MOVE;
               end
               3'd3: begin
                  k_in     = rem_by_3(rand_ff);
                  state_in = S_MOVE;
               end
               default: begin
                  k_in     = rand_ff[1:0];
                  state_in = S_MOVE;
               end
            endcase
         end
         S_MOVE: begin
            vis_we             = 1'b1;
            vis_waddr          = move_cell;
            vis_cnt_in         = vis_cnt_ff + dmc_pkg::vis_cnt_type'(1);
            cur_x_in           = move_cell[dmc_pkg::POS_W-1:0];
            cur_y_in           = move_cell[dmc_pkg::CELL_W-1:dmc_pkg::POS_W];
            res_in.carved      = 1'b1;
            res_in.wall_row    = dmc_pkg::wall_type'(cur_y_ff)
                               + dmc_pkg::wall_type'(move_cell[dmc_pkg::CELL_W-1:dmc_pkg::POS_W])
                               + dmc_pkg::wall_type'(1);
            res_in.wall_col    = dmc_pkg::wall_type'(cur_x_ff)
                               + dmc_pkg::wall_type'(move_cell[dmc_pkg::POS_W-1:0])
                               + dmc_pkg::wall_type'(1);
            res_in.backtracked = 1'b0;
            res_in.done_res    = 1'b0;
            state_in           = S_OUT;
         end
         S_POP1: begin
            res_in.carved      = 1'b0;
            res_in.wall_row    = '0;
            res_in.wall_col    = '0;
            res_in.backtracked = 1'b1;
            res_in.done_res    = 1'b0;
            // When the top is the cell we stand on, drop it and jump to the one below.
            if (stk_rdata == cur_cell) begin
               stk_cnt_in = stk_cnt_m1;
               stk_raddr  = stk_cnt_m2[dmc_pkg::STACK_AW-1:0];
               state_in   = S_POP2;
            end else begin
               cur_x_in = stk_rdata[dmc_pkg::POS_W-1:0];
               cur_y_in = stk_rdata[dmc_pkg::CELL_W-1:dmc_pkg::POS_W];
               state_in = S_OUT;
            end
         end
         S_POP2: begin
            cur_x_in = stk_rdata[dmc_pkg::POS_W-1:0];
            cur_y_in = stk_rdata[dmc_pkg::CELL_W-1:dmc_pkg::POS_W];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               xfer     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (xfer) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res_ff;
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         width_ff     <= dmc_pkg::DIM_MAX_COLS;
         height_ff    <= dmc_pkg::DIM_MAX_ROWS;
         epoch_ff     <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         stk_cnt_ff   <= '0;
         vis_cnt_ff   <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         stk_cnt_ff   <= stk_cnt_in;
         vis_cnt_ff   <= vis_cnt_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rand_ff    <= rand_in;
      free_ff    <= free_in;
      k_ff       <= k_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   dmc_ram #(
      .WIDTH (dmc_pkg::EPOCH_W),
      .DEPTH (dmc_pkg::CELLS)
   ) u_vis (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (vis_raddr),
      .rd_data (vis_rdata)
   );

   dmc_ram #(
      .WIDTH (dmc_pkg::CELL_W),
      .DEPTH (dmc_pkg::STACK_DEPTH)
   ) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (cur_cell),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   dmc_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rand_ff),
      .divisor   (rem_dvsr),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_carved      = rsp_res_ff.carved;
   assign rsp_wall_row    = rsp_res_ff.wall_row;
   assign rsp_wall_col    = rsp_res_ff.wall_col;
   assign rsp_backtracked = rsp_res_ff.backtracked;
   assign rsp_done_res    = rsp_res_ff.done_res;

`ifndef SYNTHESIS
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_cnt_ff <= dmc_pkg::STACK_FULL)
      else $error("branch stack count beyond its depth");

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      vis_cnt_ff <= dmc_pkg::CELL_TOTAL)
      else $error("visited count beyond the number of cells");

   a_move_marks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE |=> vis_cnt_ff == $past(vis_cnt_ff) + dmc_pkg::vis_cnt_type'(1))
      else $error("a carving move did not mark exactly one new cell");

   a_rem_owner: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> state_ff == S_DIV)
      else $error("remainder finished while no item waits for it");

   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && rsp_valid_ff && rsp_stall |=> state_ff == S_OUT)
      else $error("result left for a full output register");
`endif

endmodule

`default_nettype wire

FILE: sv/dmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/dmc_rem.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module dmc_rem (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire dmc_pkg::rand_type dividend,
   input  wire dmc_pkg::dim_type  divisor,
   output logic                   done,
   output dmc_pkg::dim_type       remainder
);

   localparam int CNT_W = $clog2(dmc_pkg::RAND_W);

   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   dmc_pkg::rand_type      dvd_ff, dvd_in;
   dmc_pkg::dim_type       dvsr_ff, dvsr_in;
   dmc_pkg::dim_type       rem_ff, rem_in;
   logic [dmc_pkg::DIM_W:0] trial;
   logic [dmc_pkg::DIM_W:0] diff;

   assign trial = {rem_ff, dvd_ff[dmc_pkg::RAND_W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvsr_in = divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         // The partial remainder stays below the divisor, so it fits DIM_W bits.
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = diff[dmc_pkg::DIM_W-1:0];
         end else begin
            rem_in = trial[dmc_pkg::DIM_W-1:0];
         end
         dvd_in = {dvd_ff[dmc_pkg::RAND_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(dmc_pkg::RAND_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
